/* rtl/core/cfd_pkg.sv */
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants of the clock synced feedback delay.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int MUL_W = 34;
  localparam int DIV_NW = 41;
  localparam int DIV_DW = 49;

  localparam logic [31:0] EXP2_COEF [6] = '{
    32'd1073741824, 32'd744261118, 32'd257941248,
    32'd59597083, 32'd10327388, 32'd1431680
  };

  localparam logic [27:0] TIMER_MAX = 28'hFFFFFFF;
  localparam logic [27:0] PERIOD_RESET = 28'd44100;
  localparam logic signed [15:0] TRIG_ON = 16'sd4096;
  localparam logic signed [15:0] TRIG_OFF = 16'sd204;
  localparam logic [19:0] TIME_SCALE = 20'd870822;
  localparam logic signed [23:0] PITCH_BASE = 24'sd653126;
  localparam logic signed [33:0] WET_LIMIT = 34'sd3276800;
  localparam logic [48:0] RAW_MAX = 49'h1_0000_0000_0000;
  localparam logic [24:0] PHASE_ONE = 25'h100_0000;
  // ceil(2^21 / 5), exact floor(u / 5) for u below 2^21 / 3
  localparam logic [19:0] DIV5_RECIP = 20'd419431;

  localparam logic [17:0] SAMPLE_RATE_RST = 18'd44100;
  localparam logic [15:0] TIME_KNOB_RST = 16'd44218;
  localparam logic [15:0] FEEDBACK_KNOB_RST = 16'd32768;

  typedef enum logic [2:0] {
    REG_SAMPLE_RATE = 3'd0,
    REG_TIME_KNOB = 3'd1,
    REG_FEEDBACK_KNOB = 3'd2,
    REG_TIME_CV_AMOUNT = 3'd3,
    REG_FEEDBACK_CV_AMOUNT = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  function automatic logic signed [2*MUL_W-1:0] rnd_shift(
    input logic signed [2*MUL_W-1:0] x, input int unsigned s);
    logic signed [2*MUL_W-1:0] y;
    y = x + ((2*MUL_W)'(1) << (s - 1));
    return y >>> s;
  endfunction

endpackage

/* rtl/core/cfd_mul.sv */
// ----------------------------------------------------------------------------
// cfd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module cfd_mul import cfd_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic signed [MUL_W-1:0] a,
  input  logic signed [MUL_W-1:0] b,
  output logic signed [2*MUL_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

/* rtl/core/cfd_div.sv */
// ----------------------------------------------------------------------------
// cfd_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfd_div import cfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_req_t req,
  output logic [DIV_NW-1:0] quo,
  output logic done
);

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [5:0] cnt;
  logic busy;
  logic [DIV_DW:0] trial;

  assign trial = {rem, quo[DIV_NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
        cnt <= 6'(DIV_NW);
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= DIV_DW'(trial - {1'b0, dvs});
          quo <= {quo[DIV_NW-2:0], 1'b1};
        end else begin
          rem <= trial[DIV_DW-1:0];
          quo <= {quo[DIV_NW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/cfd_ring.sv */
// ----------------------------------------------------------------------------
// cfd_ring
// Sample ring memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cfd_ring #(
  parameter int DEPTH = 262144,
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic signed [SAMPLE_BITS-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic signed [SAMPLE_BITS-1:0] rdata
);

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/clock_synced_feedback_delay.sv */
// ----------------------------------------------------------------------------
// clock_synced_feedback_delay
// Feedback delay line with an interpolated tap timed by an external clock.
// ----------------------------------------------------------------------------
// One item is taken at a time. The path from accept to result holds the
// shared multiplier's steps (feedback scaling, knob scaling, exp2 polynomial,
// period product, interpolation), two reads through the ring's read port and,
// when the delay is over one sample, the one-bit-per-cycle divider forming the
// tempo increment. The next item can be taken in the cycle after the result is
// loaded; a previous result still stalled holds the last step. After reset the
// ring is cleared one entry per cycle, during which no item is taken;
// configuration writes are taken at any time.
module clock_synced_feedback_delay import cfd_pkg::*; #(
  parameter int DEPTH = 262144,
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [23:0] in_sample,
  input  logic signed [15:0] time_cv,
  input  logic signed [15:0] feedback_cv,
  input  logic signed [15:0] clock_volts,
  input  logic clock_connected,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [22:0] wet,
  output logic signed [23:0] echo,
  output logic clock_blink
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 17;
  localparam int SB = SAMPLE_BITS;
  localparam logic signed [33:0] SMAX = 34'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [33:0] SMIN = -SMAX - 34'sd1;
  localparam logic [48:0] DLY_MIN = 49'd2 << 16;
  localparam logic [48:0] DLY_MAX = 49'(DEPTH - 2) << 16;
  localparam logic [PW-1:0] RING_SPAN = PW'(DEPTH) << 16;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CLK, S_FBD, S_FBW, S_FBQ, S_FBM, S_DRY, S_TKD, S_TKW,
    S_EXM, S_EXA, S_PLO, S_PHI, S_XS, S_SH, S_DLY, S_RA, S_RB, S_RC,
    S_WM, S_WET, S_INC, S_INW, S_PH
  } state_t;

  typedef enum logic [3:0] {
    M_FCV, M_FDIV, M_WFB, M_TK, M_TCV, M_ACC, M_PLO, M_PHI, M_DIFF
  } mul_sel_t;

  state_t state;

  logic [17:0] sample_rate;
  logic [15:0] time_knob;
  logic [15:0] feedback_knob;
  logic signed [15:0] time_cv_amount;
  logic signed [15:0] feedback_cv_amount;

  logic signed [23:0] x_in;
  logic signed [15:0] tcv, fcv, ckv;
  logic conn;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wp;
  logic signed [23:0] prev_wet;
  logic [27:0] period;
  logic [27:0] edge_timer;
  logic trig;
  logic [23:0] phase;

  logic fb_neg;
  logic [19:0] fq_u;
  logic [16:0] fb;
  logic signed [SB-1:0] dry;
  logic [19:0] tkq;
  logic [15:0] frac_e;
  logic signed [8:0] sh;
  logic [31:0] acc;
  logic [2:0] k;
  logic [43:0] plo;
  logic [61:0] xv;
  logic [48:0] raw;
  logic [AW-1:0] i0, i1;
  logic [15:0] frac;
  logic signed [SB-1:0] a_s, b_s;
  logic signed [22:0] wet_r;
  logic [24:0] inc;

  // multiplier
  mul_sel_t mul_sel;
  logic mul_en;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [SB:0] diff;

  assign diff = (SB+1)'(b_s) - (SB+1)'(a_s);

  always_comb begin
    mul_en = 1'b1;
    mul_sel = M_FCV;
    unique case (state)
      S_CLK: mul_sel = M_FCV;
      S_FBW: mul_sel = M_FDIV;
      S_FBM: mul_sel = M_WFB;
      S_DRY: mul_sel = M_TK;
      S_TKD: mul_sel = M_TCV;
      S_EXM: mul_sel = M_ACC;
      S_PLO: mul_sel = M_PLO;
      S_PHI: mul_sel = M_PHI;
      S_WM: mul_sel = M_DIFF;
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    unique case (mul_sel)
      M_FCV: begin
        mul_a = MUL_W'(fcv);
        mul_b = MUL_W'(feedback_cv_amount);
      end
      M_FDIV: begin
        mul_a = MUL_W'(fq_u);
        mul_b = MUL_W'(DIV5_RECIP);
      end
      M_WFB: begin
        mul_a = MUL_W'(prev_wet);
        mul_b = MUL_W'(fb);
      end
      M_TK: begin
        mul_a = MUL_W'(time_knob);
        mul_b = MUL_W'(TIME_SCALE);
      end
      M_TCV: begin
        mul_a = MUL_W'(tcv);
        mul_b = MUL_W'(time_cv_amount);
      end
      M_ACC: begin
        mul_a = MUL_W'(acc);
        mul_b = MUL_W'(frac_e);
      end
      M_PLO: begin
        mul_a = MUL_W'(period);
        mul_b = MUL_W'(acc[15:0]);
      end
      M_PHI: begin
        mul_a = MUL_W'(period);
        mul_b = MUL_W'(acc[31:16]);
      end
      M_DIFF: begin
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'(frac);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cfd_mul u_mul (
    .clk(clk),
    .en(mul_en),
    .a(mul_a),
    .b(mul_b),
    .p(mul_p)
  );

  // divider, tempo increment only
  div_req_t div_req;
  logic [DIV_NW-1:0] div_q;
  logic div_done;
  logic [DIV_NW-1:0] fcv_mag;

  assign fcv_mag = mul_p[2*MUL_W-1] ? DIV_NW'(-mul_p) : DIV_NW'(mul_p);

  always_comb begin
    div_req.start = (state == S_INC) && (raw > 49'd65536);
    div_req.dividend = DIV_NW'(1) << 40;
    div_req.divisor = raw;
  end

  cfd_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .quo(div_q),
    .done(div_done)
  );

  // ring
  logic ring_we;
  logic [AW-1:0] ring_waddr, ring_raddr;
  logic signed [SB-1:0] ring_wdata, ring_rdata;

  assign ring_we = (state == S_CLEAR) || (state == S_DLY);
  assign ring_waddr = (state == S_CLEAR) ? clr_addr : wp;
  assign ring_wdata = (state == S_CLEAR) ? '0 : dry;
  assign ring_raddr = (state == S_RB) ? i1 : i0;

  cfd_ring #(.DEPTH(DEPTH), .SAMPLE_BITS(SB)) u_ring (
    .clk(clk),
    .we(ring_we),
    .waddr(ring_waddr),
    .wdata(ring_wdata),
    .raddr(ring_raddr),
    .rdata(ring_rdata)
  );

  // config port
  logic [2:0] reg_sel;
  assign reg_sel = paddr[4:2];
  assign pready = 1'b1;

  always_comb begin
    case (reg_sel)
      REG_SAMPLE_RATE: prdata = 32'(sample_rate);
      REG_TIME_KNOB: prdata = 32'(time_knob);
      REG_FEEDBACK_KNOB: prdata = 32'(feedback_knob);
      REG_TIME_CV_AMOUNT: prdata = 32'(unsigned'(time_cv_amount));
      REG_FEEDBACK_CV_AMOUNT: prdata = 32'(unsigned'(feedback_cv_amount));
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SAMPLE_RATE_RST;
      time_knob <= TIME_KNOB_RST;
      feedback_knob <= FEEDBACK_KNOB_RST;
      time_cv_amount <= '0;
      feedback_cv_amount <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_SAMPLE_RATE: sample_rate <= pwdata[17:0];
        REG_TIME_KNOB: time_knob <= pwdata[15:0];
        REG_FEEDBACK_KNOB: feedback_knob <= pwdata[15:0];
        REG_TIME_CV_AMOUNT: time_cv_amount <= pwdata[15:0];
        REG_FEEDBACK_CV_AMOUNT: feedback_cv_amount <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  // datapath terms
  logic [27:0] t_inc;
  logic [37:0] t_k, sr_k;
  logic [17:0] fdq;
  logic signed [19:0] fb_sum;
  logic [35:0] tk_y;
  logic [20:0] tk_s1;
  logic [16:0] tk_s2;
  logic [15:0] tk_s3;
  logic [19:0] tk_q;
  logic signed [2*MUL_W-1:0] rnd16, rnd10;
  logic signed [33:0] dry_sum, wet_sum;
  logic signed [23:0] pitch;
  logic signed [24:0] e_v;
  logic [5:0] ls;
  logic [61:0] y_v, lmask, shr;
  logic [6:0] rs;
  logic [48:0] raw_next, dly;
  logic [PW-1:0] pos0, pos;
  logic signed [24:0] echo_sum;
  logic [24:0] ph_sum;
  logic sat;

  assign t_inc = (edge_timer != TIMER_MAX) ? edge_timer + 28'd1 : edge_timer;
  assign t_k = (38'(t_inc) << 10) - (38'(t_inc) << 4) - (38'(t_inc) << 3);
  assign sr_k = (38'(sample_rate) << 10) - (38'(sample_rate) << 4)
              - (38'(sample_rate) << 3);

  // |cv product| / 10240 as ((|p| >> 11) * recip(5)) >> 21
  assign fdq = mul_p[38:21];
  assign fb_sum = 20'(feedback_knob) + 20'(feedback_knob >> 15)
                + (fb_neg ? -20'(fdq) : 20'(fdq));

  // knob product / 65535 by folding the 16-bit digits
  assign tk_y = mul_p[35:0] + 36'd32767;
  assign tk_s1 = 21'(tk_y[35:16]) + 21'(tk_y[15:0]);
  assign tk_s2 = 17'(tk_s1[20:16]) + 17'(tk_s1[15:0]);
  assign tk_s3 = tk_s2[15:0] + 16'(tk_s2[16]);
  assign tk_q = tk_y[35:16] + 20'(tk_s1[20:16]) + 20'(tk_s2[16])
              + 20'(tk_s3 == 16'hFFFF);

  assign rnd16 = rnd_shift(mul_p, 16);
  assign rnd10 = rnd_shift(mul_p, 10);
  assign dry_sum = 34'(x_in) + rnd16[33:0];
  assign wet_sum = 34'(a_s) + rnd16[33:0];
  assign pitch = PITCH_BASE - 24'(tkq) + rnd10[23:0];
  assign e_v = 25'sd4194304 - 25'(pitch);

  always_comb begin
    ls = 6'd48 - sh[5:0];
    y_v = xv >> ls;
    lmask = (62'd1 << ls) - 62'd1;
    rs = 7'(-sh);
    shr = (rs >= 7'd62) ? '0 : (xv >> rs);
    sat = 1'b0;
    if (sh > 9'sd0) begin
      if (sh >= 9'sd48) begin
        sat = 1'b1;
      end else begin
        sat = (y_v > 62'd1) || (y_v == 62'd1 && (xv & lmask) != '0);
      end
      raw_next = sat ? RAW_MAX : 49'(xv << sh[5:0]);
    end else begin
      raw_next = (shr > 62'(RAW_MAX)) ? RAW_MAX : shr[48:0];
    end
  end

  always_comb begin
    if (raw < DLY_MIN) begin
      dly = DLY_MIN;
    end else if (raw > DLY_MAX) begin
      dly = DLY_MAX;
    end else begin
      dly = raw;
    end
    pos0 = PW'(wp) << 16;
    if (pos0 < PW'(dly)) begin
      pos0 = pos0 + RING_SPAN;
    end
    pos = pos0 - PW'(dly);
  end

  assign echo_sum = 25'(x_in) + 25'(wet_r);
  assign ph_sum = 25'(phase) + inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      wp <= '0;
      prev_wet <= '0;
      period <= PERIOD_RESET;
      edge_timer <= '0;
      trig <= 1'b0;
      phase <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_PH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            x_in <= in_sample;
            tcv <= time_cv;
            fcv <= feedback_cv;
            ckv <= clock_volts;
            conn <= clock_connected;
            state <= S_CLK;
          end
        end
        S_CLK: begin
          if (conn) begin
            if (!trig && ckv >= TRIG_ON) begin
              trig <= 1'b1;
              if (t_k >= 38'(sample_rate) && 38'(t_inc) <= sr_k) begin
                period <= t_inc;
              end
              edge_timer <= '0;
            end else begin
              edge_timer <= t_inc;
              if (trig && ckv <= TRIG_OFF) begin
                trig <= 1'b0;
              end
            end
          end else begin
            period <= 28'(sample_rate >> 1);
          end
          state <= S_FBD;
        end
        S_FBD: begin
          fb_neg <= mul_p[2*MUL_W-1];
          fq_u <= fcv_mag[30:11];
          state <= S_FBW;
        end
        S_FBW: state <= S_FBQ;
        S_FBQ: begin
          if (fb_sum < 20'sd0) begin
            fb <= '0;
          end else if (fb_sum > 20'sd65536) begin
            fb <= 17'd65536;
          end else begin
            fb <= fb_sum[16:0];
          end
          state <= S_FBM;
        end
        S_FBM: state <= S_DRY;
        S_DRY: begin
          if (dry_sum > SMAX) begin
            dry <= SMAX[SB-1:0];
          end else if (dry_sum < SMIN) begin
            dry <= SMIN[SB-1:0];
          end else begin
            dry <= dry_sum[SB-1:0];
          end
          state <= S_TKD;
        end
        S_TKD: begin
          tkq <= tk_q;
          state <= S_TKW;
        end
        S_TKW: begin
          frac_e <= e_v[15:0];
          sh <= 9'(e_v[22:16]) - 9'sd78;
          acc <= EXP2_COEF[5];
          k <= 3'd4;
          state <= S_EXM;
        end
        S_EXM: state <= S_EXA;
        S_EXA: begin
          acc <= EXP2_COEF[k] + mul_p[47:16];
          if (k == 3'd0) begin
            state <= S_PLO;
          end else begin
            k <= k - 3'd1;
            state <= S_EXM;
          end
        end
        S_PLO: state <= S_PHI;
        S_PHI: begin
          plo <= mul_p[43:0];
          state <= S_XS;
        end
        S_XS: begin
          xv <= ((62'(mul_p[43:0]) << 16) + 62'(plo)) << 1;
          state <= S_SH;
        end
        S_SH: begin
          raw <= raw_next;
          state <= S_DLY;
        end
        S_DLY: begin
          i0 <= pos[AW+15:16];
          i1 <= (pos[AW+15:16] == AW'(DEPTH - 1)) ? '0 : pos[AW+15:16] + AW'(1);
          frac <= pos[15:0];
          state <= S_RA;
        end
        S_RA: state <= S_RB;
        S_RB: begin
          a_s <= ring_rdata;
          state <= S_RC;
        end
        S_RC: begin
          b_s <= ring_rdata;
          state <= S_WM;
        end
        S_WM: state <= S_WET;
        S_WET: begin
          if (wet_sum > WET_LIMIT) begin
            wet_r <= 23'(WET_LIMIT);
          end else if (wet_sum < -WET_LIMIT) begin
            wet_r <= 23'(-WET_LIMIT);
          end else begin
            wet_r <= wet_sum[22:0];
          end
          state <= S_INC;
        end
        S_INC: begin
          if (raw > 49'd65536) begin
            state <= S_INW;
          end else begin
            inc <= PHASE_ONE;
            state <= S_PH;
          end
        end
        S_INW: begin
          if (div_done) begin
            inc <= div_q[24:0];
            state <= S_PH;
          end
        end
        S_PH: begin
          if (!out_valid || !out_stall) begin
            phase <= ph_sum[23:0];
            clock_blink <= ph_sum[24];
            wet <= wet_r;
            if (echo_sum > 25'sd8388607) begin
              echo <= 24'sd8388607;
            end else if (echo_sum < -25'sd8388608) begin
              echo <= -24'sd8388608;
            end else begin
              echo <= echo_sum[23:0];
            end
            prev_wet <= 24'(wet_r);
            wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the clock synced feedback delay item by item against a predictor of
// the ring, the feedback path, the clock tempo tracker and the interpolated
// tap, under several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb;
  import cfd_pkg::*;

  localparam int RING_DEPTH = 262144;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint unsigned RAW_CAP = 64'h1_0000_0000_0000;
  localparam longint unsigned ONE_CYCLE = 64'h100_0000;

  typedef struct {
    logic signed [23:0] smp;
    logic signed [15:0] tcv;
    logic signed [15:0] fcv;
    logic signed [15:0] cv;
    logic conn;
  } sample_item_t;

  typedef struct {
    logic signed [22:0] wet;
    logic signed [23:0] echo;
    logic blink;
  } delay_out_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic signed [23:0] in_sample = '0;
  logic signed [15:0] time_cv = '0, feedback_cv = '0, clock_volts = '0;
  logic clock_connected = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [22:0] wet;
  logic signed [23:0] echo;
  logic clock_blink;

  clock_synced_feedback_delay DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [23:0] ring [RING_DEPTH];
  longint unsigned wr_ptr, period, edge_cnt, phase;
  longint prev_wet;
  bit trig;
  longint unsigned rate, t_knob, f_knob;
  longint t_amt, f_amt;

  delay_out_t expected_q[$];
  int sender_idle_pct = 0, recv_stall_pct = 0;
  int holdoff_cycles = 0;
  int mismatches = 0, checked = 0, sent = 0, blinks = 0, configs = 0;
  longint cycles = 0;
  // square wave generator for the clock jack
  bit sq_high = 0;
  int sq_left = 0, sq_half = 4;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic delay_out_t predict_delay(sample_item_t it);
    delay_out_t r;
    longint x_in, fb, dry, pitch, e, n, sh, w, a, b;
    longint unsigned f, acc, xx, raw, dly, pos, i0, i1, inc;
    longint frac;
    x_in = it.smp;
    if (it.conn) begin
      if (edge_cnt < 64'hFFFFFFF) edge_cnt++;
      if (trig) begin
        if (it.cv <= TRIG_OFF) trig = 0;
      end else if (it.cv >= TRIG_ON) begin
        trig = 1;
        if (edge_cnt * 1000 >= rate && edge_cnt <= rate * 1000) period = edge_cnt;
        edge_cnt = 0;
      end
    end else begin
      period = rate >> 1;
    end
    fb = longint'(f_knob + (f_knob >> 15)) + (longint'(it.fcv) * f_amt) / 10240;
    fb = clampl(fb, 0, 65536);
    dry = clampl(x_in + ((prev_wet * fb + 32768) >>> 16), -8388608, 8388607);
    pitch = longint'(PITCH_BASE) - longint'((t_knob * TIME_SCALE + 32767) / 65535)
          + ((longint'(it.tcv) * t_amt + 512) >>> 10);
    e = (longint'(64) <<< 16) - pitch;
    n = (e >>> 16) - 64;
    f = longint'(e) & 64'hFFFF;
    acc = EXP2_COEF[5];
    for (int k = 4; k >= 0; k--) acc = EXP2_COEF[k] + ((acc * f) >> 16);
    xx = 2 * period * acc;
    sh = n - 14;
    if (sh > 0) begin
      if (sh >= 48 || xx > (RAW_CAP >> sh)) raw = RAW_CAP;
      else raw = xx << sh;
    end else begin
      raw = (-sh >= 63) ? 0 : (xx >> (-sh));
    end
    if (raw > RAW_CAP) raw = RAW_CAP;
    dly = raw;
    if (dly < (64'd2 << 16)) dly = 64'd2 << 16;
    if (dly > (longint'(RING_DEPTH - 2) << 16)) dly = longint'(RING_DEPTH - 2) << 16;
    ring[wr_ptr] = 24'(dry);
    pos = wr_ptr << 16;
    if (pos < dly) pos += longint'(RING_DEPTH) << 16;
    pos -= dly;
    i0 = (pos >> 16) % RING_DEPTH;
    i1 = (i0 + 1 == RING_DEPTH) ? 0 : i0 + 1;
    frac = longint'(pos & 64'hFFFF);
    a = ring[i0];
    b = ring[i1];
    w = clampl(a + (((b - a) * frac + 32768) >>> 16), -3276800, 3276800);
    prev_wet = w;
    r.wet = 23'(w);
    r.echo = 24'(clampl(x_in + w, -8388608, 8388607));
    inc = (raw == 0) ? ONE_CYCLE : ((64'd1 << 40) / raw);
    if (inc > ONE_CYCLE) inc = ONE_CYCLE;
    phase += inc;
    r.blink = 0;
    if (phase >= ONE_CYCLE) begin
      phase -= ONE_CYCLE;
      r.blink = 1;
    end
    wr_ptr = (wr_ptr + 1 >= RING_DEPTH) ? 0 : wr_ptr + 1;
    return r;
  endfunction

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = 5'(idx * 4); pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      REG_SAMPLE_RATE: rate = val[17:0];
      REG_TIME_KNOB: t_knob = val[15:0];
      REG_FEEDBACK_KNOB: f_knob = val[15:0];
      REG_TIME_CV_AMOUNT: t_amt = longint'($signed(val[15:0]));
      REG_FEEDBACK_CV_AMOUNT: f_amt = longint'($signed(val[15:0]));
      default: ;
    endcase
    configs++;
  endtask

  task automatic set_regs(logic [17:0] sr, logic [15:0] tk, logic [15:0] fk,
                          logic [15:0] ta, logic [15:0] fa);
    write_reg(REG_SAMPLE_RATE, 32'(sr));
    write_reg(REG_TIME_KNOB, 32'(tk));
    write_reg(REG_FEEDBACK_KNOB, 32'(fk));
    write_reg(REG_TIME_CV_AMOUNT, 32'(ta));
    write_reg(REG_FEEDBACK_CV_AMOUNT, 32'(fa));
  endtask

  task automatic send_item(sample_item_t it);
    int gap;
    @(negedge clk);
    in_sample = it.smp; time_cv = it.tcv; feedback_cv = it.fcv;
    clock_volts = it.cv; clock_connected = it.conn; in_valid = 1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_delay(it));
    sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(6, 1);
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [15:0] clock_level();
    if (sq_left == 0) begin
      sq_high = !sq_high;
      sq_left = $urandom_range(sq_half, 1);
    end
    sq_left--;
    if ($urandom_range(19) == 0) return 16'($urandom);
    return sq_high ? 16'($urandom_range(32767, 4096)) : -16'sd32768 + 16'($urandom_range(32972));
  endfunction

  function automatic sample_item_t rand_item(bit clocked);
    sample_item_t it;
    it.smp = 24'($urandom);
    if ($urandom_range(3) == 0) it.smp = $signed(it.smp) >>> $urandom_range(16);
    it.tcv = 16'($urandom);
    it.fcv = 16'($urandom);
    it.conn = clocked ? ($urandom_range(15) != 0) : 1'($urandom_range(1));
    it.cv = clocked ? clock_level() : 16'($urandom);
    return it;
  endfunction

  task automatic run_random(int count, bit clocked);
    repeat (count) send_item(rand_item(clocked));
  endtask

  // directed: field extremes, Schmitt thresholds, defaults after reset
  task automatic test_extremes();
    sample_item_t it;
    logic signed [15:0] lv [8] = '{16'sd0, 16'sd4095, 16'sd4096, 16'sd205, 16'sd204,
                                   16'sd32767, -16'sd32768, 16'sd4096};
    for (int i = 0; i < 16; i++) begin
      it.smp = (i % 3 == 0) ? 24'sh7FFFFF : (i % 3 == 1) ? 24'sh800000 : 24'sd0;
      it.tcv = (i % 2) ? 16'sh7FFF : 16'sh8000;
      it.fcv = (i % 4 < 2) ? 16'sh7FFF : 16'sh8000;
      it.cv = lv[i % 8];
      it.conn = (i < 12);
      send_item(it);
    end
    drain();
  endtask

  // register extremes, including zero period and out of range sample rates
  task automatic test_register_extremes();
    set_regs(18'd1000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
    run_random(40, 1);
    drain();
    set_regs(18'd0, 16'd0, 16'd0, 16'h8000, 16'h8000);
    run_random(20, 0);
    drain();
    set_regs(18'd192000, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF);
    run_random(20, 0);
    drain();
    set_regs(18'h3FFFF, 16'h8000, 16'h4000, 16'h1234, 16'hC000);
    run_random(15, 1);
    drain();
  endtask

  // short clocked delays so the tap reads back recent writes with feedback
  task automatic test_clocked_feedback();
    int pct [4] = '{0, 64, 0, 14};
    int st [4] = '{0, 0, 64, 14};
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = pct[p];
      recv_stall_pct = st[p];
      set_regs(18'($urandom_range(3000, 1000)), 16'($urandom_range(65535, 55000)),
               16'($urandom), 16'($urandom), 16'($urandom));
      sq_half = $urandom_range(12, 1);
      run_random(70, 1);
      drain();
    end
    sender_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // long receiver hold-off while items keep coming
  task automatic test_backpressure();
    set_regs(18'd1000, 16'hF000, 16'hE000, 16'h4000, 16'h2000);
    holdoff_cycles = 2000;
    run_random(40, 1);
    drain();
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items pending", cycles, expected_q.size());
      $display("** clock_synced_feedback_delay: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (holdoff_cycles > 0) begin
      holdoff_cycles--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    delay_out_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at cycle %0d", cycles);
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (exp_r.blink) blinks++;
        if (wet !== exp_r.wet || echo !== exp_r.echo || clock_blink !== exp_r.blink) begin
          mismatches++;
          if (mismatches <= 10)
            $display("item %0d: wet %0d/%0d echo %0d/%0d blink %0b/%0b (exp/got)",
                     checked, exp_r.wet, wet, exp_r.echo, echo, exp_r.blink, clock_blink);
        end
      end
    end
  end

  initial begin
    wr_ptr = 0; prev_wet = 0; edge_cnt = 0; trig = 0; phase = 0;
    rate = SAMPLE_RATE_RST; t_knob = TIME_KNOB_RST; f_knob = FEEDBACK_KNOB_RST;
    t_amt = 0; f_amt = 0; period = PERIOD_RESET;
    foreach (ring[i]) ring[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_extremes();
    test_register_extremes();
    test_clocked_feedback();
    test_backpressure();
    sender_idle_pct = 14;
    recv_stall_pct = 14;
    set_regs(18'd1500, 16'hFFFF, 16'hC000, 16'h6000, 16'hA000);
    run_random(30, 1);
    drain();
    if (expected_q.size() != 0) mismatches++;
    $display("%0d items sent, %0d results checked (%0d clock blinks), %0d register writes",
             sent, checked, blinks, configs);
    $display("%0d mismatches over %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("** clock_synced_feedback_delay: PASSED **");
    end else begin
      $display("** clock_synced_feedback_delay: FAILED **");
    end
    $finish;
  end

endmodule
